// File: hdl/ket_pkg.sv
// Shared types and constants for the key edge and repeat tracker.
// No dependencies; imported by every module in the block.
package ket_pkg;

	localparam int NUM_KEYS = 16;
	localparam int KEY_W    = 16;
	localparam int TIME_W   = 16;

	localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((2 ** NUM_KEYS) - 1);

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	localparam logic [TIME_W-1:0] FIRST_DELAY_RST     = TIME_W'(500);
	localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RST = TIME_W'(50);

	// Input tdata: key_active, window_focused, delta_time, padded to bytes.
	localparam int IN_W  = 40;
	// Output tdata: five key vectors.
	localparam int OUT_W = 5 * KEY_W;

	typedef enum logic [0:0] {
		CFG_FIRST_DELAY     = 1'b0,
		CFG_REPEAT_INTERVAL = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [TIME_W-1:0] first_delay;
		logic [TIME_W-1:0] repeat_interval;
	} ket_cfg_t;

endpackage

// File: hdl/ket_key_lane.sv
// Per-key hold timer and repeat decision for the key edge and repeat tracker.
// Depends on ket_pkg for widths and the configuration struct.
module ket_key_lane
	import ket_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  logic              was_active,
	input  logic              now_active,
	input  logic [TIME_W-1:0] delta_time,
	input  ket_cfg_t          cfg,
	output logic              repeat_fire
);

	logic [TIME_W-1:0] held_time_q;
	logic [TIME_W-1:0] held_time_d;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] sat;

	always_comb begin
		sum = {1'b0, held_time_q} + {1'b0, delta_time};
		sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		held_time_d = held_time_q;
		repeat_fire = 1'b0;
		if (now_active) begin
			if (!was_active) begin
				held_time_d = '0;
				repeat_fire = 1'b1;
			end else begin
				held_time_d = sat;
				if (sat >= cfg.first_delay) begin
					// Step back by one interval, floored at zero.
					held_time_d = (sat >= cfg.repeat_interval) ?
						sat - cfg.repeat_interval : '0;
					repeat_fire = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_time_q <= '0;
		end else if (upd) begin
			held_time_q <= held_time_d;
		end
	end

endmodule

// File: hdl/key_edge_and_repeat_tracker.sv
// Top level of the key edge and repeat tracker: input register, key state,
// per-key lanes and result register. Depends on ket_pkg and ket_key_lane.
//
// Usage: each input transaction on the s_ group is one tick carrying the
// key_active vector, the window_focused flag and delta_time in ms. Each
// tick produces exactly one result transaction on the m_ group carrying
// the down, held, up, idle and repeat vectors after that tick's update.
// An unfocused tick leaves all state alone and reports the frozen state.
// first_delay and repeat_interval are set through the cfg_ write port
// (index 0 and 1) while no tick is in flight.
// A tick is held in the input register and then in the result register.
// One tick is accepted every cycle while the receiver does not stall,
// since each key's add, saturate, compare and subtract is done in parallel
// between the input register and the result register.
// When the receiver stalls, the result register holds and s_tready drops,
// so the input register holds too; nothing is lost or repeated.
// Reset clears the key vectors, repeat flags and hold timers, and loads
// first_delay = 500 and repeat_interval = 50.
module key_edge_and_repeat_tracker
	import ket_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// [15:0] key_active, [16] window_focused, [32:17] delta_time, [39:33] zero
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// [15:0] key_down_edges, [31:16] key_held, [47:32] key_up_edges,
	// [63:48] key_idle, [79:64] key_repeat
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [TIME_W-1:0] cfg_data
);

	ket_cfg_t cfg_q;

	logic              valid_s1;
	logic [KEY_W-1:0]  key_s1;
	logic              foc_s1;
	logic [TIME_W-1:0] dt_s1;

	logic [KEY_W-1:0] prev_q, cur_q, rep_q;
	logic [KEY_W-1:0] prev_n, cur_n, rep_n, rep_lane, now_vec;
	logic             advance, upd;

	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;
	assign upd      = advance && valid_s1 && foc_s1;
	assign now_vec  = key_s1 & KEY_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_delay     <= FIRST_DELAY_RST;
			cfg_q.repeat_interval <= REPEAT_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FIRST_DELAY:     cfg_q.first_delay     <= cfg_data;
				CFG_REPEAT_INTERVAL: cfg_q.repeat_interval <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			key_s1 <= s_tdata[KEY_W-1:0];
			foc_s1 <= s_tdata[KEY_W];
			dt_s1  <= s_tdata[KEY_W+TIME_W:KEY_W+1];
		end
	end

	for (genvar k = 0; k < KEY_W; k++) begin : g_lane
		if (k < NUM_KEYS) begin : g_on
			ket_key_lane u_lane (
				.clk        (clk),
				.arst_n     (arst_n),
				.upd        (upd),
				.was_active (cur_q[k]),
				.now_active (now_vec[k]),
				.delta_time (dt_s1),
				.cfg        (cfg_q),
				.repeat_fire(rep_lane[k])
			);
		end else begin : g_off
			assign rep_lane[k] = 1'b0;
		end
	end

	always_comb begin
		prev_n = foc_s1 ? cur_q    : prev_q;
		cur_n  = foc_s1 ? now_vec  : cur_q;
		rep_n  = foc_s1 ? rep_lane : rep_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cur_q  <= '0;
			rep_q  <= '0;
		end else if (upd) begin
			prev_q <= prev_n;
			cur_q  <= cur_n;
			rep_q  <= rep_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= {rep_n & KEY_MASK,
				~prev_n & ~cur_n & KEY_MASK,
				prev_n & ~cur_n & KEY_MASK,
				prev_n & cur_n & KEY_MASK,
				~prev_n & cur_n & KEY_MASK};
		end
	end

	// A repeat can only fire on a key that is down now.
	a_repeat_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[5*KEY_W-1:4*KEY_W] &
			~(m_tdata[KEY_W-1:0] | m_tdata[2*KEY_W-1:KEY_W])) == '0))
		else $error("repeat bit set on a key that is not down");

	// Every press edge pulses its repeat bit.
	a_edge_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[KEY_W-1:0] & ~m_tdata[5*KEY_W-1:4*KEY_W]) == '0))
		else $error("press edge without repeat pulse");

	// The four state classes cover every key exactly once.
	a_classes_cover: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[KEY_W-1:0] ^ m_tdata[2*KEY_W-1:KEY_W] ^
			m_tdata[3*KEY_W-1:2*KEY_W] ^ m_tdata[4*KEY_W-1:3*KEY_W]) == KEY_MASK))
		else $error("key state classes do not partition the keys");

	// State only changes on a focused tick that moves forward.
	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> ($stable(cur_q) && $stable(prev_q) && $stable(rep_q)))
		else $error("key state changed without a focused tick");

endmodule
